/* design/lpts_pkg.sv */
// Shared types, constants and the arctangent table of the pseudo timestamp core.
`default_nettype none

package lpts_pkg;

    localparam int TIME_W      = 62;
    localparam int DUR_W       = TIME_W + 1;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_START_NS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_NS   = 2'd1;

    // Binary angles: 2^TURN_BITS units per full turn.
    localparam int TURN_BITS    = 32;
    localparam int ANGLE_W      = TURN_BITS + 2;
    localparam int PHASE_W      = TURN_BITS + 1;
    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_W     = 63;
    localparam int SCALE_POS    = 60;
    localparam int QLO_W        = 32;

    localparam logic signed [ANGLE_W-1:0] ANGLE_QUARTER = ANGLE_W'(1) << (TURN_BITS - 2);
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF    = ANGLE_W'(1) << (TURN_BITS - 1);
    localparam logic signed [ANGLE_W-1:0] ANGLE_FULL    = ANGLE_W'(1) << TURN_BITS;

    // atan(2^-i) in binary angle units, rounded to nearest
    localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
        30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
        30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
        30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
        30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
        30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005,
        30'h00000003, 30'h00000001, 30'h00000001, 30'h00000000
    };

    // Exact angle for points lying on an axis
    typedef enum logic [1:0] {
        ANG_ZERO,
        ANG_HALF,
        ANG_POS_QUARTER,
        ANG_NEG_QUARTER
    } axis_angle_t;

    typedef struct packed {
        logic        valid;
        logic        on_axis;
        axis_angle_t angle;
    } pipe_ctl_t;

endpackage

`default_nettype wire

/* design/lpts_cordic_step.sv */
// One registered CORDIC vectoring iteration.
`default_nettype none

module lpts_cordic_step #(
    parameter int STEP = 0
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    en,
    input  wire lpts_pkg::pipe_ctl_t                     ctl_in,
    input  wire logic signed [lpts_pkg::CORDIC_W-1:0]    x_in,
    input  wire logic signed [lpts_pkg::CORDIC_W-1:0]    y_in,
    input  wire logic signed [lpts_pkg::ANGLE_W-1:0]     z_in,
    output lpts_pkg::pipe_ctl_t                          ctl_out,
    output logic signed [lpts_pkg::CORDIC_W-1:0]         x_out,
    output logic signed [lpts_pkg::CORDIC_W-1:0]         y_out,
    output logic signed [lpts_pkg::ANGLE_W-1:0]          z_out
);

    localparam logic signed [lpts_pkg::ANGLE_W-1:0] ATAN_Z =
        lpts_pkg::ANGLE_W'(lpts_pkg::ATAN_TURNS[STEP]);

    lpts_pkg::pipe_ctl_t                      ctl_reg;
    logic signed [lpts_pkg::CORDIC_W-1:0]     x_reg, x_next;
    logic signed [lpts_pkg::CORDIC_W-1:0]     y_reg, y_next;
    logic signed [lpts_pkg::ANGLE_W-1:0]      z_reg, z_next;
    logic signed [lpts_pkg::CORDIC_W-1:0]     x_shr, y_shr;
    logic                                     y_pos;

    assign x_shr = x_in >>> STEP;
    assign y_shr = y_in >>> STEP;
    assign y_pos = !y_in[lpts_pkg::CORDIC_W-1] && (y_in != '0);

    // rotate toward the x axis
    always_comb begin
        if (y_pos) begin
            x_next = x_in + y_shr;
            y_next = y_in - x_shr;
            z_next = z_in + ATAN_Z;
        end else begin
            x_next = x_in - y_shr;
            y_next = y_in + x_shr;
            z_next = z_in - ATAN_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

/* design/lpts_cordic.sv */
// Azimuth pipeline: input stage, axis detection and quarter-turn prerotation, CORDIC iterations.
`default_nettype none

module lpts_cordic #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic signed [COORD_WIDTH-1:0]        point_x,
    input  wire logic signed [COORD_WIDTH-1:0]        point_y,
    output lpts_pkg::pipe_ctl_t                       ctl_out,
    output logic signed [lpts_pkg::ANGLE_W-1:0]       z_out
);

    localparam int SCALE_SH = lpts_pkg::SCALE_POS - COORD_WIDTH;
    localparam int MSB      = lpts_pkg::CORDIC_W - 1;

    logic                                     valid0_reg;
    logic signed [COORD_WIDTH-1:0]            x0_reg, y0_reg;

    lpts_pkg::pipe_ctl_t                      ctl1_reg, ctl1_next;
    logic signed [lpts_pkg::CORDIC_W-1:0]     x1_reg, x1_next;
    logic signed [lpts_pkg::CORDIC_W-1:0]     y1_reg, y1_next;
    logic signed [lpts_pkg::ANGLE_W-1:0]      z1_reg, z1_next;
    logic signed [lpts_pkg::CORDIC_W-1:0]     x_scaled, y_scaled;
    logic                                     x_zero, y_zero;

    lpts_pkg::pipe_ctl_t                      ctl_pipe [lpts_pkg::CORDIC_STEPS+1];
    logic signed [lpts_pkg::CORDIC_W-1:0]     x_pipe   [lpts_pkg::CORDIC_STEPS+1];
    logic signed [lpts_pkg::CORDIC_W-1:0]     y_pipe   [lpts_pkg::CORDIC_STEPS+1];
    logic signed [lpts_pkg::ANGLE_W-1:0]      z_pipe   [lpts_pkg::CORDIC_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= point_x;
            y0_reg <= point_y;
        end
    end

    always_comb begin
        x_scaled = lpts_pkg::CORDIC_W'(x0_reg) <<< SCALE_SH;
        y_scaled = lpts_pkg::CORDIC_W'(y0_reg) <<< SCALE_SH;
        x_zero   = (x0_reg == '0);
        y_zero   = (y0_reg == '0);

        ctl1_next.valid   = valid0_reg;
        ctl1_next.on_axis = x_zero || y_zero;
        if (y_zero) begin
            ctl1_next.angle = x0_reg[COORD_WIDTH-1] ? lpts_pkg::ANG_HALF : lpts_pkg::ANG_ZERO;
        end else begin
            ctl1_next.angle = y0_reg[COORD_WIDTH-1] ? lpts_pkg::ANG_NEG_QUARTER
                                                    : lpts_pkg::ANG_POS_QUARTER;
        end

        // fold the left half plane into the right one
        x1_next = x_scaled;
        y1_next = y_scaled;
        z1_next = '0;
        if (x_scaled[MSB]) begin
            if (!y_scaled[MSB]) begin
                x1_next = y_scaled;
                y1_next = -x_scaled;
                z1_next = lpts_pkg::ANGLE_QUARTER;
            end else begin
                x1_next = -y_scaled;
                y1_next = x_scaled;
                z1_next = -lpts_pkg::ANGLE_QUARTER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
        end
    end

    assign ctl_pipe[0] = ctl1_reg;
    assign x_pipe[0]   = x1_reg;
    assign y_pipe[0]   = y1_reg;
    assign z_pipe[0]   = z1_reg;

    for (genvar i = 0; i < lpts_pkg::CORDIC_STEPS; i++) begin : g_step
        lpts_cordic_step #(
            .STEP(i)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_pipe[i]),
            .x_in    (x_pipe[i]),
            .y_in    (y_pipe[i]),
            .z_in    (z_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .x_out   (x_pipe[i+1]),
            .y_out   (y_pipe[i+1]),
            .z_out   (z_pipe[i+1])
        );
    end

    assign ctl_out = ctl_pipe[lpts_pkg::CORDIC_STEPS];
    assign z_out   = z_pipe[lpts_pkg::CORDIC_STEPS];

endmodule

`default_nettype wire

/* design/lpts_interp.sv */
// Angle to scan fraction and time interpolation, six register stages ending in the output register.
`default_nettype none

module lpts_interp #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire lpts_pkg::pipe_ctl_t                  ctl_in,
    input  wire logic signed [lpts_pkg::ANGLE_W-1:0]  z_in,
    input  wire logic [lpts_pkg::TIME_W-1:0]          start_ns,
    input  wire logic [lpts_pkg::TIME_W-1:0]          end_ns,
    output logic                                      out_valid,
    output logic [lpts_pkg::TIME_W-1:0]               pseudo_time,
    output logic [FRACTION_BITS:0]                    scan_fraction
);

    localparam int FRAC_W  = FRACTION_BITS + 1;
    localparam int PHASE_W = lpts_pkg::PHASE_W;
    localparam int SUM_W   = PHASE_W + 1;
    localparam int QLO_W   = lpts_pkg::QLO_W;
    localparam int QHI_W   = lpts_pkg::DUR_W - FRACTION_BITS - QLO_W;
    localparam int PLO_W   = QLO_W + FRAC_W;
    localparam int PHI_W   = QHI_W + FRAC_W + 1;
    localparam int PR_W    = FRACTION_BITS + FRAC_W;
    localparam int TIME_W  = lpts_pkg::TIME_W;
    localparam int DUR_W   = lpts_pkg::DUR_W;
    localparam int STAGES  = 6;

    localparam logic [PHASE_W-1:0] PHASE_FULL = PHASE_W'(1) << lpts_pkg::TURN_BITS;
    localparam logic [SUM_W-1:0]   ROUND_HALF =
        SUM_W'(1) << (lpts_pkg::TURN_BITS - 1 - FRACTION_BITS);
    localparam logic [FRAC_W-1:0]  FRAC_ONE   = FRAC_W'(1) << FRACTION_BITS;

    logic [STAGES-1:0]                    valid_reg, valid_next;

    // stage 1: phase
    logic signed [lpts_pkg::ANGLE_W-1:0]  axis_z, z_sel, phase_sum;
    logic [PHASE_W-1:0]                   phase_reg, phase_next;

    // stage 2: fraction and duration split
    logic [SUM_W-1:0]                     round_sum, round_shr;
    logic signed [DUR_W-1:0]              dur;
    logic [FRAC_W-1:0]                    frac2_reg, frac2_next;
    logic [QLO_W-1:0]                     qlo_reg;
    logic signed [QHI_W-1:0]              qhi_reg;
    logic [FRACTION_BITS-1:0]             rem_reg;

    // stage 3: products
    logic signed [FRAC_W:0]               frac_s;
    logic [FRAC_W-1:0]                    frac3_reg;
    logic [PLO_W-1:0]                     plo_reg, plo_next;
    logic signed [PHI_W-1:0]              phi_reg, phi_next;
    logic [PR_W-1:0]                      pr_reg, pr_next;

    // stages 4 to 6: sums
    logic [FRAC_W-1:0]                    frac4_reg, frac5_reg, frac6_reg;
    logic [TIME_W-1:0]                    sum_reg, sum_next;
    logic [FRAC_W-1:0]                    rterm_reg;
    logic [TIME_W-1:0]                    off_reg, off_next;
    logic [TIME_W-1:0]                    time_reg, time_next;

    assign valid_next = {valid_reg[STAGES-2:0], ctl_in.valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        case (ctl_in.angle)
            lpts_pkg::ANG_ZERO:        axis_z = '0;
            lpts_pkg::ANG_HALF:        axis_z = lpts_pkg::ANGLE_HALF;
            lpts_pkg::ANG_POS_QUARTER: axis_z = lpts_pkg::ANGLE_QUARTER;
            lpts_pkg::ANG_NEG_QUARTER: axis_z = -lpts_pkg::ANGLE_QUARTER;
            default:                   axis_z = '0;
        endcase
        z_sel     = ctl_in.on_axis ? axis_z : z_in;
        phase_sum = z_sel + lpts_pkg::ANGLE_HALF;
        // clamp to [0, one turn]
        if (phase_sum[lpts_pkg::ANGLE_W-1]) begin
            phase_next = '0;
        end else if (phase_sum > lpts_pkg::ANGLE_FULL) begin
            phase_next = PHASE_FULL;
        end else begin
            phase_next = phase_sum[PHASE_W-1:0];
        end
    end

    always_comb begin
        round_sum = {1'b0, phase_reg} + ROUND_HALF;
        round_shr = round_sum >> (lpts_pkg::TURN_BITS - FRACTION_BITS);
        if (round_shr > SUM_W'(FRAC_ONE)) begin
            frac2_next = FRAC_ONE;
        end else begin
            frac2_next = round_shr[FRAC_W-1:0];
        end
        dur = signed'({1'b0, end_ns}) - signed'({1'b0, start_ns});
    end

    assign frac_s   = signed'({1'b0, frac2_reg});
    assign plo_next = PLO_W'(qlo_reg) * PLO_W'(frac2_reg);
    assign phi_next = qhi_reg * frac_s;
    assign pr_next  = PR_W'(rem_reg) * PR_W'(frac2_reg);

    // only the low bits of the high product survive the time width
    assign sum_next  = {phi_reg[TIME_W-QLO_W-1:0], QLO_W'(0)} + TIME_W'(plo_reg);
    assign off_next  = sum_reg + TIME_W'(rterm_reg);
    assign time_next = start_ns + off_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= phase_next;

            frac2_reg <= frac2_next;
            // floor(dur / 2^FB) split into a low unsigned and a high signed part
            qlo_reg   <= dur[FRACTION_BITS +: QLO_W];
            qhi_reg   <= dur[DUR_W-1 -: QHI_W];
            rem_reg   <= dur[FRACTION_BITS-1:0];

            frac3_reg <= frac2_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            pr_reg    <= pr_next;

            frac4_reg <= frac3_reg;
            sum_reg   <= sum_next;
            rterm_reg <= pr_reg[PR_W-1 -: FRAC_W];

            frac5_reg <= frac4_reg;
            off_reg   <= off_next;

            frac6_reg <= frac5_reg;
            time_reg  <= time_next;
        end
    end

    assign out_valid     = valid_reg[STAGES-1];
    assign pseudo_time   = time_reg;
    assign scan_fraction = frac6_reg;

endmodule

`default_nettype wire

/* design/lidar_point_pseudo_timestamp_core.sv */
// Lidar point pseudo timestamp core: azimuth to scan fraction to interpolated capture time.
//
// Input stream s_*: one lidar point per beat, x and y in two's complement.
// Output stream m_*: one result per point, in order: the capture time
// start + floor(fraction * (end - start)) in nanoseconds and
// the scan fraction (pi + atan2(y, x)) / (2 pi) in unsigned Q1.FRACTION_BITS.
// Config channel cfg_*: index 0 writes the scan start time, index 1 the scan
// end time; other indexes are dropped. Write it only while no point is in
// flight; cfg_ready is always high.
// From an accepted input beat to m_tvalid, a point passes an input stage,
// one prerotation stage, 32 CORDIC iteration stages and six stages of
// fraction and interpolation arithmetic, the last being the output register.
// Throughput is one point per cycle while the output does not stall; every stage
// after the input stage is fed by one CORDIC add/subtract, multiply or wide add.
// Reset clears both time registers to zero and empties the pipeline.
// While a result waits with m_tready low, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module lidar_point_pseudo_timestamp_core #(
    parameter int COORD_WIDTH   = 24,
    parameter int FRACTION_BITS = 16,
    localparam int S_TDATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((lpts_pkg::TIME_W + FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [S_TDATA_W-1:0]               s_tdata,   // point_x, point_y

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [M_TDATA_W-1:0]                    m_tdata,   // pseudo_time, scan_fraction

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lpts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lpts_pkg::TIME_W-1:0]        cfg_data
);

    logic                                 en;
    logic [lpts_pkg::TIME_W-1:0]          start_ns_reg, start_ns_next;
    logic [lpts_pkg::TIME_W-1:0]          end_ns_reg, end_ns_next;
    logic signed [COORD_WIDTH-1:0]        point_x, point_y;
    lpts_pkg::pipe_ctl_t                  cordic_ctl;
    logic signed [lpts_pkg::ANGLE_W-1:0]  cordic_z;
    logic                                 out_valid;
    logic [lpts_pkg::TIME_W-1:0]          pseudo_time;
    logic [FRACTION_BITS:0]               scan_fraction;

    assign cfg_ready = 1'b1;

    always_comb begin
        start_ns_next = start_ns_reg;
        end_ns_next   = end_ns_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lpts_pkg::REG_START_NS: start_ns_next = cfg_data;
                lpts_pkg::REG_END_NS:   end_ns_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ns_reg <= '0;
            end_ns_reg   <= '0;
        end else begin
            start_ns_reg <= start_ns_next;
            end_ns_reg   <= end_ns_next;
        end
    end

    // advance every stage unless a result is stuck in the output register
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    assign point_x = s_tdata[COORD_WIDTH-1:0];
    assign point_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    lpts_cordic #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .point_x  (point_x),
        .point_y  (point_y),
        .ctl_out  (cordic_ctl),
        .z_out    (cordic_z)
    );

    lpts_interp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_interp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .ctl_in        (cordic_ctl),
        .z_in          (cordic_z),
        .start_ns      (start_ns_reg),
        .end_ns        (end_ns_reg),
        .out_valid     (out_valid),
        .pseudo_time   (pseudo_time),
        .scan_fraction (scan_fraction)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'({scan_fraction, pseudo_time});

endmodule

`default_nettype wire

/* design/lpts_checker.sv */
// Port-level assertions for the pseudo timestamp core, bound to the top level.
`default_nettype none

module lpts_checker #(
    parameter int FRACTION_BITS = 16,
    localparam int M_TDATA_W    = ((lpts_pkg::TIME_W + FRACTION_BITS + 1 + 7) / 8) * 8
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    localparam logic [FRACTION_BITS+1:0] FRAC_ONE = (FRACTION_BITS + 2)'(1) << FRACTION_BITS;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // a stuck result freezes the pipeline, so the input side must not take a beat
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input beat taken while output stalled");

    a_empty_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input refused with empty output register");

    a_fraction_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && s_tvalid |-> {1'b0, m_tdata[lpts_pkg::TIME_W +: FRACTION_BITS+1]} <= FRAC_ONE
        || !m_tvalid)
        else $error("scan fraction above one");

endmodule

bind lidar_point_pseudo_timestamp_core lpts_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_lpts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the lidar point pseudo timestamp core.

module tb_top;

    localparam int TIME_W         = lpts_pkg::TIME_W;
    localparam int CFG_INDEX_W    = lpts_pkg::CFG_INDEX_W;
    localparam int TURN_BITS      = lpts_pkg::TURN_BITS;
    localparam int SCALE_POS      = lpts_pkg::SCALE_POS;
    localparam int CORDIC_STEPS   = lpts_pkg::CORDIC_STEPS;

    localparam int COORD_W        = 24;
    localparam int FRAC_W         = 16;
    localparam int S_W            = 48;
    localparam int M_W            = 80;
    localparam int PIPE_LATENCY   = 40;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_POINTS   = 125;
    localparam int CYCLE_LIMIT    = 1000000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [TIME_W-1:0] NS_MAX = '1;
    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

    localparam longint QUARTER_TURN = 64'sd1 <<< (TURN_BITS - 2);
    localparam longint HALF_TURN    = 64'sd1 <<< (TURN_BITS - 1);
    localparam longint FULL_TURN    = 64'sd1 <<< TURN_BITS;
    localparam longint FRAC_ONE     = 64'sd1 <<< FRAC_W;

    typedef struct packed {
        logic [TIME_W-1:0] pseudo_time;
        logic [FRAC_W:0]   scan_fraction;
    } stamp_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [M_W-1:0]    m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data  = '0;

    // Mirror of the scan registers
    logic [TIME_W-1:0] start_ns = '0;
    logic [TIME_W-1:0] end_ns   = '0;

    logic [S_W-1:0] point_q [$];
    stamp_t         stamp_q [$];
    stamp_t         want;

    bit  send_idle_en = 1'b0;
    bit  recv_idle_en = 1'b0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  errors       = 0;
    int  points_sent  = 0;
    int  stamps_seen  = 0;
    int  cycle_count  = 0;

    lidar_point_pseudo_timestamp_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // point_x, point_y
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // pseudo_time, scan_fraction
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Binary angle of (px, py), 2^32 per turn
    function automatic longint point_azimuth(longint px, longint py);
        longint x, y, z, t, xs, ys;
        x = px;
        y = py;
        z = 0;
        if (y == 0) begin
            return (x < 0) ? HALF_TURN : 0;
        end
        if (x == 0) begin
            return (y > 0) ? QUARTER_TURN : -QUARTER_TURN;
        end
        x = x <<< (SCALE_POS - COORD_W);
        y = y <<< (SCALE_POS - COORD_W);
        // rotate left half plane points into the right half plane
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QUARTER_TURN;
            end else begin
                x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + longint'(lpts_pkg::ATAN_TURNS[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(lpts_pkg::ATAN_TURNS[i]);
            end
        end
        return z;
    endfunction

    function automatic stamp_t predict_stamp(logic [S_W-1:0] beat);
        logic signed [COORD_W-1:0] cx, cy;
        longint px, py, phase, frac, dur, q, r, off, stamp_ns;
        stamp_t s;
        cx = beat[COORD_W-1:0];
        cy = beat[2*COORD_W-1:COORD_W];
        px = cx;
        py = cy;
        phase = point_azimuth(px, py) + HALF_TURN;
        if (phase < 0) phase = 0;
        if (phase > FULL_TURN) phase = FULL_TURN;
        frac = (phase + (64'sd1 <<< (TURN_BITS - FRAC_W - 1))) >>> (TURN_BITS - FRAC_W);
        if (frac > FRAC_ONE) frac = FRAC_ONE;
        // split the signed duration so nothing overflows 64 bits
        dur = longint'({2'b00, end_ns}) - longint'({2'b00, start_ns});
        q = dur >>> FRAC_W;
        r = dur - (q <<< FRAC_W);
        off = q * frac + ((r * frac) >>> FRAC_W);
        stamp_ns = longint'({2'b00, start_ns}) + off;
        s.pseudo_time   = stamp_ns[TIME_W-1:0];
        s.scan_fraction = frac[FRAC_W:0];
        return s;
    endfunction

    function automatic int pick_gap(bit idle_en);
        int unsigned roll;
        if (!idle_en) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [TIME_W-1:0] random_ns();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TIME_W-1:0];
    endfunction

    function automatic logic [S_W-1:0] random_point();
        logic signed [COORD_W-1:0] x, y;
        logic signed [COORD_W-1:0] edges [5];
        logic [31:0] a;
        edges = '{C_MIN, C_MAX, -24'sd1, 24'sd0, 24'sd1};
        a = $urandom();
        x = a[COORD_W-1:0];
        a = $urandom();
        y = a[COORD_W-1:0];
        case ($urandom_range(0, 9))
            4: begin
                x = COORD_W'($urandom_range(0, 32)) - 24'sd16;
                y = COORD_W'($urandom_range(0, 32)) - 24'sd16;
            end
            5: begin
                if ($urandom_range(0, 1)) x = '0;
                else y = '0;
            end
            6: begin
                y = $urandom_range(0, 1) ? x : -x;
            end
            7: begin
                x = edges[$urandom_range(0, 4)];
                y = edges[$urandom_range(0, 4)];
            end
            8: begin
                x[COORD_W-1] = 1'b1;
                y = COORD_W'($urandom_range(0, 64)) - 24'sd32;
            end
            9: begin
                x[COORD_W-1] = 1'b1;
                y = COORD_W'($urandom_range(0, 2)) - 24'sd1;
            end
            default: ;
        endcase
        return {y, x};
    endfunction

    // Point driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                stamp_q.push_back(predict_stamp(s_tdata));
                points_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (point_q.size() != 0) begin
                    s_tdata  <= point_q.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_idle_en);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                stamps_seen++;
                if (stamp_q.size() == 0) begin
                    $display("%0t: result beat with nothing pending, tdata %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = stamp_q.pop_front();
                    if (m_tdata[TIME_W-1:0] !== want.pseudo_time) begin
                        $display("%0t: pseudo_time expected %0d actual %0d", $time,
                                 want.pseudo_time, m_tdata[TIME_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[TIME_W+FRAC_W:TIME_W] !== want.scan_fraction) begin
                        $display("%0t: scan_fraction expected %0d actual %0d", $time,
                                 want.scan_fraction, m_tdata[TIME_W+FRAC_W:TIME_W]);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = pick_gap(recv_idle_en);
            end
        end
    end

    // Register mirror
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_ns <= '0;
            end_ns   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lpts_pkg::REG_START_NS: start_ns <= cfg_data;
                lpts_pkg::REG_END_NS:   end_ns   <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, stamp_q.size());
            $display("lidar_point_pseudo_timestamp_core: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [TIME_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every sent point has come back, then let the pipe settle
    task automatic wait_drained();
        do @(negedge aclk); while (point_q.size() != 0 || s_tvalid || stamp_q.size() != 0);
        repeat (PIPE_LATENCY + 5) @(negedge aclk);
    endtask

    task automatic add_point(int x, int y);
        point_q.push_back({COORD_W'(y), COORD_W'(x)});
    endtask

    initial begin
        logic [TIME_W-1:0] base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed points under the reset scan times
        add_point(0, 0);        add_point(1, 0);        add_point(C_MAX, 0);
        add_point(-1, 0);       add_point(C_MIN, 0);    add_point(0, 1);
        add_point(0, C_MAX);    add_point(0, -1);       add_point(0, C_MIN);
        add_point(C_MAX, C_MAX); add_point(C_MIN, C_MIN); add_point(C_MIN, C_MAX);
        add_point(C_MAX, C_MIN); add_point(1, 1);       add_point(-1, -1);
        add_point(-1, 1);       add_point(1, -1);       add_point(C_MIN, 1);
        add_point(C_MIN, -1);   add_point(-1, C_MIN);   add_point(3, -4);
        add_point(-1000, 7);
        wait_drained();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(lpts_pkg::REG_START_NS, '0);
                    write_reg(lpts_pkg::REG_END_NS, NS_MAX);
                end
                2: begin
                    write_reg(lpts_pkg::REG_START_NS, NS_MAX);
                    write_reg(lpts_pkg::REG_END_NS, '0);
                end
                3: write_reg(lpts_pkg::REG_END_NS, NS_MAX);
                4: begin
                    base = random_ns() >> 1;
                    write_reg(lpts_pkg::REG_START_NS, base);
                    write_reg(lpts_pkg::REG_END_NS, base + $urandom_range(0, 200000000));
                end
                5: begin
                    // spare indexes must not disturb the scan times
                    write_reg(REG_SPARE_LO, random_ns());
                    write_reg(REG_SPARE_HI, random_ns());
                    write_reg(lpts_pkg::REG_END_NS, random_ns());
                end
                7: begin
                    base = random_ns() | (62'd1 << 61);
                    write_reg(lpts_pkg::REG_START_NS, base);
                    write_reg(lpts_pkg::REG_END_NS, base - $urandom_range(0, 70000));
                end
                8: begin
                    write_reg(lpts_pkg::REG_START_NS, '0);
                    write_reg(lpts_pkg::REG_END_NS, '0);
                end
                default: begin
                    write_reg(lpts_pkg::REG_START_NS, random_ns());
                    write_reg(lpts_pkg::REG_END_NS, random_ns());
                end
            endcase
            send_idle_en = (ph % 3 != 0);
            recv_idle_en = (ph % 4 != 1);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                point_q.push_back(random_point());
                // pause the sender mid-scan until everything is back
                if (ph == 6 && n == PHASE_POINTS / 2) wait_drained();
            end
            wait_drained();
        end

        $display("%0d points checked (%0d results) over %0d scan time settings", points_sent,
                 stamps_seen, NUM_PHASES + 1);
        $display("covered origin, axes, extremes, left half plane and random azimuths");
        if (errors == 0 && stamp_q.size() == 0) begin
            $display("lidar_point_pseudo_timestamp_core: match");
        end else begin
            $display("lidar_point_pseudo_timestamp_core: mismatch");
        end
        $finish;
    end

endmodule

/* lidar_point_pseudo_timestamp_core.f */
design/lpts_pkg.sv
design/lpts_cordic_step.sv
design/lpts_cordic.sv
design/lpts_interp.sv
design/lidar_point_pseudo_timestamp_core.sv
design/lpts_checker.sv
dv/tb_top.sv
